FILE: rtl/core/dwvr_pkg.sv
// Shared types and operation and status codes of the deque with value removal.
package dwvr_pkg;

    typedef logic [1:0]         t_mode;
    typedef logic [1:0]         t_status;
    typedef logic signed [31:0] t_value;

    localparam t_mode MODE_PUSH_FRONT = 2'd0;
    localparam t_mode MODE_PUSH_BACK  = 2'd1;
    localparam t_mode MODE_REMOVE     = 2'd2;
    localparam t_mode MODE_DUMP       = 2'd3;

    localparam t_status STAT_OK    = 2'd0;
    localparam t_status STAT_FULL  = 2'd1;
    localparam t_status STAT_EMPTY = 2'd2;

endpackage

FILE: rtl/core/deque_with_value_removal_unit.sv
// Bounded deque of signed values with push front/back, remove-all-equal and dump.
//
// Input channel (i_in_valid / o_in_ready) carries one operation per beat:
// i_mode and i_data_value. Output channel (o_out_valid / i_out_ready) carries
// one result per beat; o_last marks the final result of an operation.
// Entries live in a CAPACITY-deep synchronous memory with a registered read port.
// Push: one result, loaded into the output register on the accept cycle.
// Remove: walks every entry once through the memory read port, one entry a
//   cycle, writing survivors back packed, then gives one result with the
//   kept and removed totals, also on an empty list.
// Dump: streams one entry a cycle from the memory read port while the receiver
//   takes them; an empty list gives a single result with status empty.
// One operation is in flight at a time; the next is accepted once the walk is
// over and the output register is free or being taken.
// Reset clears the front position, the entry count and the output valid; the
// memory needs no clearing. A stalled receiver holds the output register and
// pauses a dump walk without loss.
module deque_with_value_removal_unit #(
    parameter int CAPACITY = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  dwvr_pkg::t_mode                  i_mode,
    input  dwvr_pkg::t_value                 i_data_value,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output dwvr_pkg::t_status                o_status,
    output dwvr_pkg::t_value                 o_entry_value,
    output logic [$clog2(CAPACITY+1)-1:0]    o_entry_total,
    output logic [$clog2(CAPACITY+1)-1:0]    o_removed_total,
    output logic                             o_last
);
    import dwvr_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int SUM_W = CNT_W + 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RM   = 2'd1;
    localparam logic [1:0] S_DP   = 2'd2;

    function automatic logic [IDX_W-1:0] f_slot(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(off);
        if (sum >= SUM_W'(CAPACITY)) begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return sum[IDX_W-1:0];
    endfunction

    t_value r_mem [CAPACITY];
    t_value r_rd_data;

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_front, n_front;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_kept, n_kept;
    t_value           r_key, n_key;
    logic             r_rd_vld, n_rd_vld;
    logic             r_rd_last, n_rd_last;

    logic             r_out_valid, n_out_valid;
    t_status          r_status, n_status;
    t_value           r_value, n_value;
    logic [CNT_W-1:0] r_total, n_total;
    logic [CNT_W-1:0] r_removed, n_removed;
    logic             r_last, n_last;

    logic             w_we, w_re;
    logic [IDX_W-1:0] w_waddr, w_raddr;
    t_value           w_wdata;
    logic             w_out_free, w_in_fire, w_take, w_issue;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && w_out_free;
    assign w_in_fire  = i_in_valid && o_in_ready;
    assign w_take     = (r_state == S_DP) && r_rd_vld && w_out_free;
    assign w_issue    = (r_idx != r_count) && (!r_rd_vld || w_out_free);

    always_comb begin
        n_state     = r_state;
        n_front     = r_front;
        n_count     = r_count;
        n_idx       = r_idx;
        n_kept      = r_kept;
        n_key       = r_key;
        n_rd_vld    = r_rd_vld;
        n_rd_last   = r_rd_last;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_value     = r_value;
        n_total     = r_total;
        n_removed   = r_removed;
        n_last      = r_last;
        w_we        = 1'b0;
        w_re        = 1'b0;
        w_waddr     = '0;
        w_raddr     = '0;
        w_wdata     = i_data_value;

        unique case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    unique case (i_mode)
                        MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
                            n_out_valid = 1'b1;
                            n_value     = '0;
                            n_removed   = '0;
                            n_last      = 1'b1;
                            if (r_count >= CNT_W'(CAPACITY)) begin
                                n_status = STAT_FULL;
                                n_total  = r_count;
                            end else begin
                                w_we     = 1'b1;
                                n_count  = r_count + 1'b1;
                                n_status = STAT_OK;
                                n_total  = r_count + 1'b1;
                                if (i_mode == MODE_PUSH_FRONT) begin
                                    n_front = (r_front == '0) ?
                                              IDX_W'(CAPACITY - 1) : r_front - 1'b1;
                                    w_waddr = n_front;
                                end else begin
                                    w_waddr = f_slot(r_front, r_count);
                                end
                            end
                        end
                        MODE_REMOVE: begin
                            n_key    = i_data_value;
                            n_idx    = '0;
                            n_kept   = '0;
                            n_rd_vld = 1'b0;
                            n_state  = S_RM;
                        end
                        MODE_DUMP: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                                n_status    = STAT_EMPTY;
                                n_value     = '0;
                                n_total     = '0;
                                n_removed   = '0;
                                n_last      = 1'b1;
                            end else begin
                                n_idx    = '0;
                                n_rd_vld = 1'b0;
                                n_state  = S_DP;
                            end
                        end
                    endcase
                end
            end
            S_RM: begin
                if (r_rd_vld && (r_rd_data != r_key)) begin
                    w_we    = 1'b1;
                    w_waddr = f_slot(r_front, r_kept);
                    w_wdata = r_rd_data;
                    n_kept  = r_kept + 1'b1;
                end
                if (r_idx != r_count) begin
                    w_re     = 1'b1;
                    w_raddr  = f_slot(r_front, r_idx);
                    n_idx    = r_idx + 1'b1;
                    n_rd_vld = 1'b1;
                end else begin
                    n_rd_vld = 1'b0;
                    if (!r_rd_vld && w_out_free) begin
                        n_out_valid = 1'b1;
                        n_status    = STAT_OK;
                        n_value     = '0;
                        n_total     = r_kept;
                        n_removed   = r_count - r_kept;
                        n_last      = 1'b1;
                        n_count     = r_kept;
                        n_state     = S_IDLE;
                    end
                end
            end
            S_DP: begin
                if (w_take) begin
                    n_out_valid = 1'b1;
                    n_status    = STAT_OK;
                    n_value     = r_rd_data;
                    n_total     = r_count;
                    n_removed   = '0;
                    n_last      = r_rd_last;
                end
                if (w_issue) begin
                    w_re      = 1'b1;
                    w_raddr   = f_slot(r_front, r_idx);
                    n_idx     = r_idx + 1'b1;
                    n_rd_vld  = 1'b1;
                    n_rd_last = (CNT_W'(r_idx + 1'b1) == r_count);
                end else if (w_take) begin
                    n_rd_vld = 1'b0;
                end
                if ((r_idx == r_count) && !r_rd_vld) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_front     <= n_front;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_kept      <= n_kept;
            r_rd_vld    <= n_rd_vld;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_rd_last <= n_rd_last;
        r_status  <= n_status;
        r_value   <= n_value;
        r_total   <= n_total;
        r_removed <= n_removed;
        r_last    <= n_last;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_value   = r_value;
    assign o_entry_total   = r_total;
    assign o_removed_total = r_removed;
    assign o_last          = r_last;

endmodule
